// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the region cache.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be seen outside reset.
`define RCL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hw/rtl/rcl_pkg.sv
// ----------------------------------------------------------------------------
// Region cache package
// Command, residency and status codes, and the transaction and row types.
// ----------------------------------------------------------------------------
`default_nettype none

package rcl_pkg;

  localparam logic [2:0] CMD_COMPLETE = 3'd0;
  localparam logic [2:0] CMD_ACTIVE   = 3'd1;
  localparam logic [2:0] CMD_INACTIVE = 3'd2;
  localparam logic [2:0] CMD_EVICT    = 3'd3;
  localparam logic [2:0] CMD_DEMAND   = 3'd4;
  localparam logic [2:0] CMD_QUERY    = 3'd5;
  localparam logic [2:0] CMD_CLEAR    = 3'd6;

  localparam logic [2:0] RES_UNLOADED = 3'd0;
  localparam logic [2:0] RES_READING  = 3'd1;
  localparam logic [2:0] RES_PREPARED = 3'd2;
  localparam logic [2:0] RES_ACTIVE   = 3'd3;
  localparam logic [2:0] RES_DORMANT  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_UNLOADED  = 2'd2;

  localparam logic [31:0] TICK_MAX    = 32'hFFFF_FFFF;
  localparam logic [6:0]  LIMIT_RESET = 7'd64;
  localparam logic [37:0] BYTES_RESET = 38'h3F_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  region;
    logic [31:0] payload_bytes;
    logic        activate_flag;
    logic        dormant_flag;
    logic        demand_value;
  } req_t;

  typedef struct packed {
    logic [6:0] victim_region;
    logic [1:0] status;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  residency;
    logic [31:0] last_use;
    logic [31:0] payload_size;
    logic        actor_flag;
  } row_t;

endpackage

`default_nettype wire

// File: hw/rtl/rcl_row_ram.sv
// ----------------------------------------------------------------------------
// Region row memory
// One write and one registered read port; per-row valid bits make unwritten
// rows read as all zero, which is the cleared table.
// ----------------------------------------------------------------------------
`default_nettype none

module rcl_row_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            clr,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire rcl_pkg::row_t   wdata,
  input  wire logic [AW-1:0]   raddr,
  output rcl_pkg::row_t        rdata
);

  rcl_pkg::row_t mem [DEPTH];
  logic [DEPTH-1:0] vld;
  rcl_pkg::row_t rd_q;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/rcl_cfg.sv
// ----------------------------------------------------------------------------
// Region cache configuration registers
// APB-style access to the region count limit and the byte limit.
// ----------------------------------------------------------------------------
`default_nettype none

module rcl_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output logic [6:0]       region_limit,
  output logic [37:0]      byte_limit
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_limit <= rcl_pkg::LIMIT_RESET;
      byte_limit   <= rcl_pkg::BYTES_RESET;
    end else if (wr) begin
      if (paddr[3]) begin
        byte_limit <= pwdata[37:0];
      end else begin
        region_limit <= pwdata[6:0];
      end
    end
  end

  assign prdata = paddr[3] ? {26'd0, byte_limit} : {57'd0, region_limit};

endmodule

`default_nettype wire

// File: hw/rtl/region_cache_lru_eviction.sv
// ----------------------------------------------------------------------------
// Region cache with LRU eviction
// Residency table with count and byte budgets; eviction queries walk the
// table once per victim, tracking the oldest dormant and prepared candidates.
// ----------------------------------------------------------------------------
//
//   channel   signals                         moves
//   req       req_valid / req_ready / req     one command transaction
//   rsp       rsp_valid / rsp_ready / rsp     one result transaction
//   apb       psel penable pwrite paddr ...   register writes and reads
//
// An update command reads the row, modifies and writes it back, then hands
// the result to the output register.
// A query first totals the budgets, then runs a budget check, a table scan and
// a pick per victim; each result is emitted, waiting out any output stalls.
// Reset clears the table at once through per-row valid bits; no sweep.
// req_ready is high only while the sequencer is idle; a result waiting in
// the output register does not block the next command from being taken.
//
`default_nettype none

`include "assert_macros.svh"

module region_cache_lru_eviction #(
  parameter int REGION_COUNT = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rcl_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rcl_pkg::rsp_t      rsp,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_SUM, S_SFIN, S_PICK, S_PFIN, S_CHK, S_EMIT
  } state_t;

  state_t state;

  logic [6:0]  region_limit;
  logic [37:0] byte_limit;

  rcl_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .region_limit(region_limit), .byte_limit(byte_limit)
  );

  // Row memory and its access controls.
  logic          clr;
  logic          we;
  rcl_pkg::row_t wrow;
  logic [IDX_W-1:0] raddr;
  rcl_pkg::row_t rrow;

  // Latched command.
  rcl_pkg::req_t    cur;
  logic [IDX_W-1:0] cur_idx;
  logic [31:0]      use_tick;
  logic [31:0]      tick_next;

  // Scan pipeline: address issued this cycle, row returns the next.
  logic [IDX_W-1:0] scan_addr;
  logic             issue_done;
  logic             p_valid;
  logic [IDX_W-1:0] p_idx;

  // Budget totals and victim bookkeeping.
  logic [6:0]        count;
  logic [37:0]       bytes;
  logic [REGION_COUNT-1:0] picked;
  logic              d_found, p_found;
  logic [IDX_W-1:0]  d_idx, p_best;
  logic [31:0]       d_last, p_last;
  logic [31:0]       d_pay, p_pay;
  logic              has_pend;
  logic [IDX_W-1:0]  pend;

  // Result waiting for the output register.
  rcl_pkg::rsp_t e_rsp;
  logic          e_cont;

  logic over;
  logic cand_base;
  logic in_range;
  logic loaded;
  logic [IDX_W-1:0] v_idx;
  logic [31:0]      v_pay;
  logic [37:0]      bytes_less;

  rcl_row_ram #(.DEPTH(REGION_COUNT), .AW(IDX_W)) u_ram (
    .clk(clk), .rst(rst), .clr(clr), .we(we), .waddr(cur_idx), .wdata(wrow),
    .raddr(raddr), .rdata(rrow)
  );

  assign req_ready = (state == S_IDLE);
  assign raddr     = (state == S_RD) ? cur_idx : scan_addr;
  assign tick_next = (use_tick == rcl_pkg::TICK_MAX) ? use_tick : use_tick + 32'd1;
  assign over      = (count > region_limit) || (bytes > byte_limit);
  assign in_range  = (req.region != 7'd0) && (req.region <= 7'(REGION_COUNT));
  assign loaded    = (rrow.residency == rcl_pkg::RES_PREPARED) ||
                     (rrow.residency == rcl_pkg::RES_ACTIVE) ||
                     (rrow.residency == rcl_pkg::RES_DORMANT);
  assign cand_base = p_valid && !rrow.actor_flag && !picked[p_idx];
  assign v_idx     = d_found ? d_idx : p_best;
  assign v_pay     = d_found ? d_pay : p_pay;
  assign bytes_less = (bytes > {6'd0, v_pay}) ? bytes - {6'd0, v_pay} : 38'd0;

  // Write-back row of an update command.
  always_comb begin
    wrow = rrow;
    we   = 1'b0;
    clr  = (state == S_IDLE) && req_valid && (req.command == rcl_pkg::CMD_CLEAR);
    if (state == S_RDW) begin
      case (cur.command)
        rcl_pkg::CMD_COMPLETE: begin
          we                = 1'b1;
          wrow.residency    = cur.activate_flag ? rcl_pkg::RES_ACTIVE
                                                : rcl_pkg::RES_PREPARED;
          wrow.last_use     = tick_next;
          wrow.payload_size = cur.payload_bytes;
        end
        rcl_pkg::CMD_ACTIVE: begin
          we             = loaded;
          wrow.residency = rcl_pkg::RES_ACTIVE;
          wrow.last_use  = tick_next;
        end
        rcl_pkg::CMD_INACTIVE: begin
          we             = loaded;
          wrow.residency = cur.dormant_flag ? rcl_pkg::RES_DORMANT
                                            : rcl_pkg::RES_PREPARED;
          wrow.last_use  = tick_next;
        end
        rcl_pkg::CMD_EVICT: begin
          we                = 1'b1;
          wrow.residency    = rcl_pkg::RES_UNLOADED;
          wrow.last_use     = 32'd0;
          wrow.payload_size = 32'd0;
        end
        rcl_pkg::CMD_DEMAND: begin
          we              = 1'b1;
          wrow.actor_flag = cur.demand_value;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      use_tick   <= 32'd0;
      rsp_valid  <= 1'b0;
      p_valid    <= 1'b0;
      issue_done <= 1'b0;
      has_pend   <= 1'b0;
      e_cont     <= 1'b0;
    end else begin
      // The emit state reloads the output register itself.
      if (rsp_valid && rsp_ready && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur     <= req;
            cur_idx <= IDX_W'(req.region - 7'd1);
            e_cont  <= 1'b0;
            e_rsp   <= '{victim_region: 7'd0,
                         status: ((req.command < rcl_pkg::CMD_QUERY) && !in_range)
                                 ? rcl_pkg::ST_RANGE : rcl_pkg::ST_OK,
                         last: 1'b1};
            if (req.command == rcl_pkg::CMD_QUERY) begin
              state      <= S_SUM;
              scan_addr  <= '0;
              issue_done <= 1'b0;
              count      <= 7'd0;
              bytes      <= 38'd0;
            end else if (req.command == rcl_pkg::CMD_CLEAR) begin
              use_tick <= 32'd0;
              state    <= S_EMIT;
            end else if (req.command > rcl_pkg::CMD_CLEAR) begin
              state <= S_EMIT;
            end else if (!in_range) begin
              state <= S_EMIT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          if ((cur.command == rcl_pkg::CMD_ACTIVE || cur.command == rcl_pkg::CMD_INACTIVE)
              && !loaded) begin
            e_rsp.status <= rcl_pkg::ST_UNLOADED;
          end
          if (cur.command == rcl_pkg::CMD_COMPLETE ||
              ((cur.command == rcl_pkg::CMD_ACTIVE || cur.command == rcl_pkg::CMD_INACTIVE)
               && loaded)) begin
            use_tick <= tick_next;
          end
          state <= S_EMIT;
        end
        S_SUM, S_PICK: begin
          // The valid flag drops by itself once the last address is issued.
          p_valid <= !issue_done;
          p_idx   <= scan_addr;
          if (!issue_done) begin
            if (scan_addr == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          if (state == S_SUM) begin
            if (p_valid && (rrow.residency == rcl_pkg::RES_PREPARED ||
                            rrow.residency == rcl_pkg::RES_DORMANT)) begin
              count <= count + 7'd1;
              bytes <= bytes + {6'd0, rrow.payload_size};
            end
          end else begin
            if (cand_base && rrow.residency == rcl_pkg::RES_DORMANT &&
                (!d_found || rrow.last_use < d_last)) begin
              d_found <= 1'b1;
              d_idx   <= p_idx;
              d_last  <= rrow.last_use;
              d_pay   <= rrow.payload_size;
            end
            if (cand_base && rrow.residency == rcl_pkg::RES_PREPARED &&
                (!p_found || rrow.last_use < p_last)) begin
              p_found <= 1'b1;
              p_best  <= p_idx;
              p_last  <= rrow.last_use;
              p_pay   <= rrow.payload_size;
            end
          end
          if (p_valid && p_idx == LAST_IDX) begin
            state <= (state == S_SUM) ? S_SFIN : S_PFIN;
          end
        end
        S_SFIN: begin
          has_pend <= 1'b0;
          picked   <= '0;
          if (over) begin
            state <= S_CHK;
          end else begin
            state <= S_EMIT;
          end
        end
        S_PFIN: begin
          if (!d_found && !p_found) begin
            // No candidate left: the held victim, if any, closes the query.
            e_rsp <= '{victim_region: has_pend ? 7'(pend) + 7'd1 : 7'd0,
                       status: rcl_pkg::ST_OK, last: 1'b1};
            e_cont <= 1'b0;
            state  <= S_EMIT;
          end else begin
            picked[v_idx] <= 1'b1;
            count         <= count - 7'd1;
            bytes         <= bytes_less;
            pend          <= v_idx;
            has_pend      <= 1'b1;
            if (has_pend) begin
              e_rsp  <= '{victim_region: 7'(pend) + 7'd1, status: rcl_pkg::ST_OK,
                          last: 1'b0};
              e_cont <= 1'b1;
              state  <= S_EMIT;
            end else begin
              state <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (over) begin
            state      <= S_PICK;
            scan_addr  <= '0;
            issue_done <= 1'b0;
            d_found    <= 1'b0;
            p_found    <= 1'b0;
          end else begin
            e_rsp  <= '{victim_region: 7'(pend) + 7'd1, status: rcl_pkg::ST_OK,
                        last: 1'b1};
            e_cont <= 1'b0;
            state  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= e_rsp;
            state     <= e_cont ? S_CHK : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A command keeps the sequencer busy in the cycle after it is taken.
  `RCL_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "accept not busy")
  // A nonzero victim always names a region of the table.
  `RCL_ASSERT_NEVER(a_victim_range, rsp_valid && (rsp.victim_region > 7'(REGION_COUNT)),
    "victim out of range")
  // An error status is a lone final result with no victim.
  `RCL_ASSERT(a_err_alone,
    rsp_valid && (rsp.status != rcl_pkg::ST_OK) |-> rsp.last && (rsp.victim_region == 7'd0),
    "error result malformed")

endmodule

`default_nettype wire
